@@ src/bbr_pkg.sv @@
package bbr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // column counter indexes the line buffers, row counter runs up to height+1
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam int WIDTH_RESET  = 800;
  localparam int HEIGHT_RESET = 600;

  localparam int PIX_W    = 32;
  localparam int CH_W     = 8;
  localparam int RGB_W    = 3 * CH_W;
  localparam int COLSUM_W = 10;
  localparam int WINSUM_W = 12;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // window columns held in the cell chain (the current column is not stored)
  localparam int NUM_CELLS = 2;

  // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
  localparam int DIV9_MUL   = 7282;
  localparam int DIV9_SHIFT = 16;
  localparam int PROD_W     = WINSUM_W + DIV9_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [RGB_W-1:0] rgb_t;

  typedef struct packed {
    logic [COLSUM_W-1:0] r;
    logic [COLSUM_W-1:0] g;
    logic [COLSUM_W-1:0] b;
  } col_sum_t;

  typedef struct packed {
    logic [WINSUM_W-1:0] r;
    logic [WINSUM_W-1:0] g;
    logic [WINSUM_W-1:0] b;
  } win_sum_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    rgb_t             prev;
    rgb_t             prev2;
  } lb_wr_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } out_item_t;

  function automatic col_sum_t col_add(input rgb_t a, input rgb_t b, input rgb_t c);
    col_sum_t s;
    s.r = COLSUM_W'(a[2*CH_W +: CH_W]) + COLSUM_W'(b[2*CH_W +: CH_W])
        + COLSUM_W'(c[2*CH_W +: CH_W]);
    s.g = COLSUM_W'(a[CH_W +: CH_W]) + COLSUM_W'(b[CH_W +: CH_W])
        + COLSUM_W'(c[CH_W +: CH_W]);
    s.b = COLSUM_W'(a[0 +: CH_W]) + COLSUM_W'(b[0 +: CH_W])
        + COLSUM_W'(c[0 +: CH_W]);
    return s;
  endfunction

  function automatic win_sum_t win_add(input col_sum_t near, input col_sum_t far,
                                       input col_sum_t cur, input logic use_far,
                                       input logic use_cur);
    win_sum_t s;
    s.r = WINSUM_W'(near.r) + (use_far ? WINSUM_W'(far.r) : '0)
        + (use_cur ? WINSUM_W'(cur.r) : '0);
    s.g = WINSUM_W'(near.g) + (use_far ? WINSUM_W'(far.g) : '0)
        + (use_cur ? WINSUM_W'(cur.g) : '0);
    s.b = WINSUM_W'(near.b) + (use_far ? WINSUM_W'(far.b) : '0)
        + (use_cur ? WINSUM_W'(cur.b) : '0);
    return s;
  endfunction

  function automatic logic [CH_W-1:0] div9(input logic [WINSUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(DIV9_MUL);
    return p[DIV9_SHIFT +: CH_W];
  endfunction

endpackage

@@ src/bbr_col_cell.sv @@
module bbr_col_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbr_pkg::cell_ctrl_t ctrl_i,
  input  bbr_pkg::col_sum_t   sum_i,
  output bbr_pkg::col_sum_t   sum_o
);
  import bbr_pkg::*;

  col_sum_t sum_q;

  // one window column, kept as per-channel sums of its three rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.clear) begin
      sum_q <= '0;
    end else if (ctrl_i.shift) begin
      sum_q <= sum_i;
    end
  end

  assign sum_o = sum_q;

endmodule

@@ src/bbr_line_buf.sv @@
module bbr_line_buf (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [bbr_pkg::COL_W-1:0] rd_addr_i,
  input  bbr_pkg::lb_wr_t          wr_i,
  output bbr_pkg::rgb_t            prev_o,
  output bbr_pkg::rgb_t            prev2_o
);
  import bbr_pkg::*;

  rgb_t mem_prev  [MAX_WIDTH];
  rgb_t mem_prev2 [MAX_WIDTH];
  rgb_t prev_q;
  rgb_t prev2_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_prev[wr_i.addr]  <= wr_i.prev;
      mem_prev2[wr_i.addr] <= wr_i.prev2;
    end
    if (rd_en_i) begin
      // same column written in this cycle (one pixel per line): forward it
      if (wr_i.en && wr_i.addr == rd_addr_i) begin
        prev_q  <= wr_i.prev;
        prev2_q <= wr_i.prev2;
      end else begin
        prev_q  <= mem_prev[rd_addr_i];
        prev2_q <= mem_prev2[rd_addr_i];
      end
    end
  end

  assign prev_o  = prev_q;
  assign prev2_o = prev2_q;

endmodule

@@ src/bbr_out_buf.sv @@
module bbr_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_valid_i,
  input  bbr_pkg::out_item_t res_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bbr_pkg::out_item_t out_o
);
  import bbr_pkg::*;

  logic      out_valid_q;
  logic      skid_valid_q;
  out_item_t out_q;
  out_item_t skid_q;
  logic      take;

  assign take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid_i) begin
      if (out_valid_q && !take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (res_valid_i) begin
      if (out_valid_q && !take) begin
        skid_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");
`endif

endmodule

@@ src/box_blur_3x3_rgba.sv @@
// 3x3 box blur over an RGBA8888 raster stream. One pixel is taken per clock
// and the block keeps that rate as long as the output side does not stall;
// the limit is the single write and read port of each 24-bit line buffer,
// used once per pixel. A result leaves width+1 transfers after its pixel
// went in (plus the a, c and output registers), so after each frame
// the source sends width+1 flush items; the last of them carries frame_last.
// Sums skip neighbors outside the frame but always divide by 9, so borders
// come out darker; alpha out is always 0xFF. Writing frame_width or
// frame_height restarts the frame; the user does so only while the block is idle
// (not enforced by the block). Out-of-range sizes are clamped to 1..1024.
module box_blur_3x3_rgba (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bbr_pkg::PIX_W-1:0]     pixel_in_i,
  input  logic                          flush_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bbr_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                          frame_last_o,
  input  logic                          cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbr_pkg::CFG_W-1:0]     cfg_data_i
);
  import bbr_pkg::*;

  logic             en;
  logic             accept;
  logic             buf_full;

  logic [COL_W-1:0] w_m1_q;
  logic [ROW_W-1:0] h_q;
  logic [COL_W-1:0] w_m1_new;
  logic [ROW_W-1:0] h_new;
  logic [ROW_W-1:0] h_p1;

  logic [COL_W-1:0] in_column_q, in_column_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;

  rgb_t             cur_d;
  logic             emit_d, last_d, use_left_d, use_cur_d, has_top_d, has_mid_d;

  // stage a: item registered, line buffer read in flight
  logic             a_valid_q;
  logic [COL_W-1:0] a_ix_q;
  rgb_t             a_cur_q;
  logic             a_emit_q, a_last_q, a_use_left_q, a_use_cur_q, a_has_top_q, a_has_mid_q;

  rgb_t             lb_prev, lb_prev2;
  rgb_t             top, mid;
  lb_wr_t           lb_wr;

  cell_ctrl_t       cell_ctrl;
  col_sum_t         cell_sum [NUM_CELLS+1];
  win_sum_t         win_sum;

  // stage c: window sum registered
  logic             c_valid_q;
  logic             c_last_q;
  win_sum_t         c_sum_q;

  out_item_t        res;
  out_item_t        out_item;

  assign en         = !buf_full;
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && en;

  // register value clamping
  always_comb begin
    if (cfg_data_i == '0) begin
      w_m1_new = '0;
    end else if (int'(cfg_data_i) > MAX_WIDTH) begin
      w_m1_new = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_m1_new = COL_W'(cfg_data_i - 1'b1);
    end
    if (cfg_data_i == '0) begin
      h_new = ROW_W'(1);
    end else if (int'(cfg_data_i) > MAX_HEIGHT) begin
      h_new = ROW_W'(MAX_HEIGHT);
    end else begin
      h_new = ROW_W'(cfg_data_i);
    end
  end

  assign h_p1 = h_q + ROW_W'(1);

  // position decode of the incoming item
  always_comb begin
    cur_d      = (flush_i || in_row_q >= h_q) ? '0 : pixel_in_i[PIX_W-1:CH_W];
    has_top_d  = in_row_q >= ROW_W'(2);
    has_mid_d  = in_row_q != '0;
    use_cur_d  = in_column_q != '0;
    emit_d     = has_top_d || (in_row_q == ROW_W'(1) && use_cur_d);
    use_left_d = in_column_q >= COL_W'(2) || (in_column_q == '0 && w_m1_q != '0);
    last_d     = in_row_q == h_p1 && in_column_q == '0;
    if (last_d) begin
      in_column_d = '0;
      in_row_d    = '0;
    end else if (in_column_q == w_m1_q) begin
      in_column_d = '0;
      in_row_d    = in_row_q + ROW_W'(1);
    end else begin
      in_column_d = in_column_q + COL_W'(1);
      in_row_d    = in_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_m1_q      <= COL_W'(WIDTH_RESET - 1);
      h_q         <= ROW_W'(HEIGHT_RESET);
      in_column_q <= '0;
      in_row_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  w_m1_q <= w_m1_new;
        REG_FRAME_HEIGHT: h_q    <= h_new;
        default:          ;
      endcase
      in_column_q <= '0;
      in_row_q    <= '0;
    end else if (accept) begin
      in_column_q <= in_column_d;
      in_row_q    <= in_row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= accept;
      c_valid_q <= a_valid_q && a_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ix_q       <= in_column_q;
      a_cur_q      <= cur_d;
      a_emit_q     <= emit_d;
      a_last_q     <= last_d;
      a_use_left_q <= use_left_d;
      a_use_cur_q  <= use_cur_d;
      a_has_top_q  <= has_top_d;
      a_has_mid_q  <= has_mid_d;
      c_last_q     <= a_last_q;
      c_sum_q      <= win_sum;
    end
  end

  // stage b: finish the column, shift the cell chain, write back the lines
  assign top = a_has_top_q ? lb_prev2 : '0;
  assign mid = a_has_mid_q ? lb_prev : '0;

  assign lb_wr.en    = en && a_valid_q;
  assign lb_wr.addr  = a_ix_q;
  assign lb_wr.prev  = a_cur_q;
  assign lb_wr.prev2 = mid;

  bbr_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_column_q),
    .wr_i      (lb_wr),
    .prev_o    (lb_prev),
    .prev2_o   (lb_prev2)
  );

  assign cell_ctrl.shift = en && a_valid_q;
  assign cell_ctrl.clear = cfg_we_i;
  assign cell_sum[0]     = col_add(top, mid, a_cur_q);

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    bbr_col_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .sum_i  (cell_sum[k]),
      .sum_o  (cell_sum[k+1])
    );
  end

  assign win_sum = win_add(cell_sum[1], cell_sum[NUM_CELLS], cell_sum[0],
                           a_use_left_q, a_use_cur_q);

  // divide by 9 on the way into the output register
  assign res.pixel = {div9(c_sum_q.r), div9(c_sum_q.g), div9(c_sum_q.b), ALPHA_OPAQUE};
  assign res.last  = c_last_q;

  bbr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (c_valid_q && en),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_item)
  );

  assign pixel_out_o  = out_item.pixel;
  assign frame_last_o = out_item.last;

`ifndef ASSERT_OFF
  a_column_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_column_q <= w_m1_q)
    else $error("column counter beyond line width");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && a_last_q |-> a_ix_q == '0 && a_emit_q)
    else $error("frame end item without a result");

  a_frozen_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(a_valid_q) && $stable(c_valid_q))
    else $error("pipeline moved while output buffer full");
`endif

endmodule
